// ===== src/fss_pkg.sv =====
// Package for the FIX session sequencer: item types and the codes they carry.
// Used by every module in src; depends on nothing.
package fss_pkg;

   // action codes
   localparam logic [1:0] ACT_CONNECT = 2'd0;
   localparam logic [1:0] ACT_MESSAGE = 2'd1;
   localparam logic [1:0] ACT_TICK    = 2'd2;
   localparam logic [1:0] ACT_FILL    = 2'd3;

   // inbound message kinds
   localparam logic [2:0] KIND_LOGON    = 3'd0;
   localparam logic [2:0] KIND_LOGOUT   = 3'd1;
   localparam logic [2:0] KIND_HBEAT    = 3'd2;
   localparam logic [2:0] KIND_TEST_REQ = 3'd3;
   localparam logic [2:0] KIND_ORDER    = 3'd4;
   localparam logic [2:0] KIND_CANCEL   = 3'd5;

   // outbound send kinds
   localparam logic [2:0] SEND_NONE    = 3'd0;
   localparam logic [2:0] SEND_SIGNON  = 3'd1;
   localparam logic [2:0] SEND_SIGNOFF = 3'd2;
   localparam logic [2:0] SEND_HBEAT   = 3'd3;
   localparam logic [2:0] SEND_EXEC    = 3'd4;

   // session modes
   localparam logic [1:0] MODE_WAIT   = 2'd0;
   localparam logic [1:0] MODE_ACTIVE = 2'd1;
   localparam logic [1:0] MODE_LOGOUT = 2'd2;
   localparam logic [1:0] MODE_CLOSED = 2'd3;

   // tick counters saturate here
   localparam int unsigned CNT_W = 18;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [15:0] HB_RESET = 16'd30;

   typedef struct packed {
      logic [1:0]  action;
      logic [2:0]  msg_kind;
      logic [30:0] in_seq_num;
      logic        has_test_id;
   } req_type;

   typedef struct packed {
      logic [2:0]  send_kind;
      logic [31:0] send_seq;
      logic        echo_test_id;
      logic        forward_order;
      logic        seq_gap;
      logic        disconnect;
      logic [1:0]  session_mode;
   } rsp_type;

endpackage

// ===== src/fss_core.sv =====
// Session state and per-item decision logic of the FIX session sequencer.
// Depends on fss_pkg for the item types and codes.
module fss_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [15:0]      csr_write_data,
   input  logic             fire,
   input  fss_pkg::req_type item,
   output fss_pkg::rsp_type result
);

   logic [15:0]               hb_ff;
   logic [1:0]                mode_ff, mode_in;
   logic [31:0]               exp_seq_ff, exp_seq_in;
   logic [31:0]               out_seq_ff, out_seq_in;
   logic [fss_pkg::CNT_W-1:0] tsend_ff, tsend_in;
   logic [fss_pkg::CNT_W-1:0] trecv_ff, trecv_in;

   // work out the result and next state for the item in the input register
   always_comb begin
      logic [31:0]               seq32;
      logic [fss_pkg::CNT_W-1:0] tsend_inc, trecv_inc;
      logic                      take;
      logic [1:0]                shown;

      seq32     = {1'b0, item.in_seq_num};
      tsend_inc = (tsend_ff != fss_pkg::CNT_MAX) ? tsend_ff + 1'b1 : tsend_ff;
      trecv_inc = (trecv_ff != fss_pkg::CNT_MAX) ? trecv_ff + 1'b1 : trecv_ff;
      take      = 1'b0;

      mode_in    = mode_ff;
      exp_seq_in = exp_seq_ff;
      out_seq_in = out_seq_ff;
      tsend_in   = tsend_ff;
      trecv_in   = trecv_ff;
      result     = '0;

      if (item.action == fss_pkg::ACT_CONNECT) begin
         mode_in    = fss_pkg::MODE_WAIT;
         exp_seq_in = 32'd1;
         out_seq_in = 32'd1;
         tsend_in   = '0;
         trecv_in   = '0;
      end else if (mode_ff != fss_pkg::MODE_CLOSED) begin
         case (item.action)
            fss_pkg::ACT_MESSAGE: begin
               trecv_in = '0;
               if (seq32 != 32'd0) begin
                  result.seq_gap = (seq32 != exp_seq_ff);
                  exp_seq_in     = seq32 + 32'd1;
               end
               case (item.msg_kind)
                  fss_pkg::KIND_LOGON: begin
                     if (mode_ff == fss_pkg::MODE_WAIT) begin
                        mode_in          = fss_pkg::MODE_ACTIVE;
                        result.send_kind = fss_pkg::SEND_SIGNON;
                        take             = 1'b1;
                     end
                  end
                  fss_pkg::KIND_LOGOUT: begin
                     mode_in           = fss_pkg::MODE_LOGOUT;
                     result.send_kind  = fss_pkg::SEND_SIGNOFF;
                     result.disconnect = 1'b1;
                     take              = 1'b1;
                  end
                  fss_pkg::KIND_TEST_REQ: begin
                     result.send_kind    = fss_pkg::SEND_HBEAT;
                     result.echo_test_id = item.has_test_id;
                     take                = 1'b1;
                  end
                  fss_pkg::KIND_ORDER, fss_pkg::KIND_CANCEL: begin
                     result.forward_order = (mode_ff == fss_pkg::MODE_ACTIVE);
                  end
                  default: begin
                  end
               endcase
            end
            fss_pkg::ACT_TICK: begin
               tsend_in = tsend_inc;
               trecv_in = trecv_inc;
               if (mode_ff == fss_pkg::MODE_ACTIVE) begin
                  if (tsend_inc >= {2'b00, hb_ff}) begin
                     result.send_kind = fss_pkg::SEND_HBEAT;
                     take             = 1'b1;
                  end
                  if (trecv_inc > {1'b0, hb_ff, 1'b0}) begin
                     result.disconnect = 1'b1;
                     mode_in           = fss_pkg::MODE_CLOSED;
                  end
               end
            end
            default: begin
               if (mode_ff == fss_pkg::MODE_ACTIVE) begin
                  result.send_kind = fss_pkg::SEND_EXEC;
                  take             = 1'b1;
               end
            end
         endcase
      end

      // a send takes the next outbound number and restarts the send timer
      if (take) begin
         result.send_seq = out_seq_ff;
         out_seq_in      = out_seq_ff + 32'd1;
         tsend_in        = '0;
      end

      // a logout shows its own mode once, then the session is closed
      shown               = mode_in;
      result.session_mode = shown;
      if (shown == fss_pkg::MODE_LOGOUT) begin
         mode_in = fss_pkg::MODE_CLOSED;
      end
   end

   // hold the interval register and session state
   always_ff @(posedge clock) begin
      if (reset) begin
         hb_ff      <= fss_pkg::HB_RESET;
         mode_ff    <= fss_pkg::MODE_CLOSED;
         exp_seq_ff <= 32'd1;
         out_seq_ff <= 32'd1;
         tsend_ff   <= '0;
         trecv_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            hb_ff <= csr_write_data;
         end
         if (fire) begin
            mode_ff    <= mode_in;
            exp_seq_ff <= exp_seq_in;
            out_seq_ff <= out_seq_in;
            tsend_ff   <= tsend_in;
            trecv_ff   <= trecv_in;
         end
      end
   end

   // the stored mode is never the transient logout mode
   assert property (@(posedge clock) disable iff (reset)
      mode_ff != fss_pkg::MODE_LOGOUT)
      else $error("logout mode stored");

   // a send always advances the outbound number by one
   assert property (@(posedge clock) disable iff (reset)
      fire && result.send_kind != fss_pkg::SEND_NONE
      |=> out_seq_ff == $past(out_seq_ff) + 32'd1)
      else $error("outbound sequence not advanced");

   // a closed session ignores everything but a connect
   assert property (@(posedge clock) disable iff (reset)
      fire && mode_ff == fss_pkg::MODE_CLOSED && item.action != fss_pkg::ACT_CONNECT
      |-> result.send_kind == fss_pkg::SEND_NONE && mode_in == fss_pkg::MODE_CLOSED)
      else $error("closed session acted on an item");

endmodule

// ===== src/fss_out_reg.sv =====
// Result register of the FIX session sequencer, with valid/stall towards the receiver.
// Depends on fss_pkg for the result item type.
module fss_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load_valid,
   input  fss_pkg::rsp_type load_data,
   output logic             advance,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fss_pkg::rsp_type rsp_payload
);

   logic             valid_ff;
   fss_pkg::rsp_type data_ff;

   // advance when empty or when the held item is taken
   assign advance = !valid_ff || !rsp_stall;

   // hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load_valid) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

// ===== src/fix_session_sequencer.sv =====
// Top level of the FIX session sequencer: input register, session core, result register.
// Depends on fss_pkg, fss_core and fss_out_reg.
//
// Usage:
//   req_valid/req_stall/req_payload carry one item: connect, parsed inbound
//   message, tick or fill. Each item gives exactly one result item on
//   rsp_valid/rsp_stall/rsp_payload, in order.
//   csr_write_enable/csr_write_data set the heartbeat interval in ticks;
//   write it only while no item is in flight.
// Flow: an accepted item is registered in the input register, decided by the
//   session core and loaded into the result register when that register
//   advances; the receiver takes it from there.
// Throughput: one item per cycle while rsp_stall is low; the session state is
//   updated in one pass of compares and increments, so nothing in the core iterates.
// Reset: synchronous, active high. Both registers empty, session closed,
//   sequence numbers 1, tick counters 0, interval 30.
// Stall: while rsp_stall holds a waiting result, the input register keeps one
//   more item and req_stall rises only once that register is also full.
module fix_session_sequencer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  fss_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output fss_pkg::rsp_type rsp_payload,
   input  logic             csr_write_enable,
   input  logic [15:0]      csr_write_data
);

   logic             in_valid_ff;
   fss_pkg::req_type in_data_ff;
   logic             advance;
   logic             fire;
   fss_pkg::rsp_type result;

   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   // take a new item whenever the input register empties or moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_payload;
      end
   end

   fss_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fire             (fire),
      .item             (in_data_ff),
      .result           (result)
   );

   fss_out_reg u_out (
      .clock       (clock),
      .reset       (reset),
      .load_valid  (in_valid_ff),
      .load_data   (result),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // no send means no sequence number
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.send_kind == fss_pkg::SEND_NONE |-> rsp_payload.send_seq == 32'd0)
      else $error("sequence number without a send");

   // a disconnect shows a logging out or closed session
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.disconnect
      |-> rsp_payload.session_mode == fss_pkg::MODE_LOGOUT
          || rsp_payload.session_mode == fss_pkg::MODE_CLOSED)
      else $error("disconnect on an open session");

   // the input side stalls only with a full input register behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid && rsp_stall)
      else $error("input stalled without cause");

endmodule
